// ===== design/ovl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_DELETE = 3'd2,
        OP_MODIFY = 3'd3,
        OP_DUMP   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // what every cell does with its word this cycle
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_SHIFT  = 2'd2,
        CMD_ROTATE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic cmp_en;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== design/ovl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ovl_cell (
    input  wire logic                       i_clk,
    input  wire ovl_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic                       i_sel,
    input  wire logic                       i_after,
    input  wire logic [ovl_pkg::DATA_W-1:0] i_key,
    input  wire logic [ovl_pkg::DATA_W-1:0] i_wdata,
    input  wire logic [ovl_pkg::DATA_W-1:0] i_next,
    output logic      [ovl_pkg::DATA_W-1:0] o_data,
    output logic                            o_match
);

    logic [ovl_pkg::DATA_W-1:0] r_data;
    logic                       r_match;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.cmd)
            ovl_pkg::CMD_HOLD: begin
                r_data <= r_data;
            end
            ovl_pkg::CMD_WRITE: begin
                if (i_sel) begin
                    r_data <= i_wdata;
                end
            end
            // close the gap: this cell and all after the hit take the neighbor's word
            ovl_pkg::CMD_SHIFT: begin
                if (i_after) begin
                    r_data <= i_next;
                end
            end
            // head wraps around to the tail cell
            ovl_pkg::CMD_ROTATE: begin
                r_data <= i_sel ? i_wdata : i_next;
            end
            default: begin
                r_data <= r_data;
            end
        endcase
        if (i_ctrl.cmp_en) begin
            r_match <= (r_data == i_key);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ===== design/ordered_value_list_table.sv =====
// insert, search, delete and modify: a request is taken while idle; its result is registered from
// the resolve state once the output register has room; o_stall holds off new requests until idle
// dump: taken while idle, resolved in the resolve state, then one entry per cycle from the head cell
// while the output register has room; a stalled result word holds the sequencer where it is
// all cells compare against the key in parallel in the accept cycle; dump rotates the cell chain
// reset (synchronous, active low) empties the list and clears the handshake; cell words are kept
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_opcode,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_new_value,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_value,
    output logic                    o_last
);

    localparam int DEPTH = ovl_pkg::LIST_DEPTH;
    localparam int DW    = ovl_pkg::DATA_W;
    localparam int CW    = ovl_pkg::CNT_W;

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RES  = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state r_state, n_state;

    // request word held while it resolves
    logic [2:0]    r_op;
    logic [DW-1:0] r_key;
    logic [DW-1:0] r_nv;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;

    // output register
    logic          r_o_valid;
    logic [1:0]    r_status, n_status;
    logic [DW-1:0] r_value, n_value;
    logic          r_last, n_last;

    // cell chain
    logic [DW-1:0] w_data [DEPTH];
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_occ;
    logic [DEPTH-1:0] w_ins_sel;
    logic [DEPTH-1:0] w_tail_sel;
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH-1:0] w_first;
    logic [DEPTH-1:0] w_after;
    logic [DEPTH-1:0] w_sel;
    logic [DW-1:0]    w_hit_value;
    logic [DW-1:0]    w_wdata;
    ovl_pkg::t_cell_ctrl w_ctrl;

    logic w_accept;
    logic w_slot;
    logic w_emit;
    logic w_full;
    logic w_empty;

    assign w_accept = i_valid && !o_stall;
    // output register can take a word this cycle
    assign w_slot   = !r_o_valid || !i_stall;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign o_stall  = (r_state != S_IDLE);

    // per-cell position decodes against the fill count
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_occ[k]      = (CW'(k) < r_count);
            w_ins_sel[k]  = (CW'(k) == r_count);
            w_tail_sel[k] = (CW'(k + 1) == r_count);
        end
    end

    // first match: isolate lowest hit, then mark it and everything past it
    assign w_hit   = w_match & w_occ;
    assign w_first = w_hit & (~w_hit + DEPTH'(1));
    assign w_after = ~(w_first - DEPTH'(1));

    always_comb begin
        w_hit_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_hit_value = w_hit_value | (w_data[k] & {DW{w_first[k]}});
        end
    end

    // cells
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DW-1:0] w_next;
            if (g == DEPTH - 1) begin : g_end
                assign w_next = w_data[g];
            end else begin : g_mid
                assign w_next = w_data[g+1];
            end
            ovl_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_sel   (w_sel[g]),
                .i_after (w_after[g]),
                .i_key   (i_key),
                .i_wdata (w_wdata),
                .i_next  (w_next),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    // control
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_status   = r_status;
        n_value    = r_value;
        n_last     = r_last;
        w_emit     = 1'b0;
        w_ctrl.cmd = ovl_pkg::CMD_HOLD;
        // match bits are captured as the request comes in
        w_ctrl.cmp_en = w_accept;
        w_sel      = '0;
        w_wdata    = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RES;
                end
            end

            S_RES: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                    n_last  = 1'b1;
                    n_value = '0;
                    unique case (r_op)
                        ovl_pkg::OP_INSERT: begin
                            w_emit = 1'b1;
                            if (w_full) begin
                                n_status = ovl_pkg::ST_FULL;
                            end else begin
                                w_ctrl.cmd = ovl_pkg::CMD_WRITE;
                                w_sel      = w_ins_sel;
                                w_wdata    = r_key;
                                n_count    = r_count + CW'(1);
                                n_status   = ovl_pkg::ST_DONE;
                                n_value    = r_key;
                            end
                        end
                        ovl_pkg::OP_SEARCH, ovl_pkg::OP_DELETE, ovl_pkg::OP_MODIFY: begin
                            w_emit = 1'b1;
                            if (w_empty) begin
                                n_status = ovl_pkg::ST_EMPTY;
                            end else if (w_hit == '0) begin
                                n_status = ovl_pkg::ST_NOT_FOUND;
                            end else begin
                                n_status = ovl_pkg::ST_DONE;
                                n_value  = w_hit_value;
                                if (r_op == ovl_pkg::OP_DELETE) begin
                                    w_ctrl.cmd = ovl_pkg::CMD_SHIFT;
                                    n_count    = r_count - CW'(1);
                                end else if (r_op == ovl_pkg::OP_MODIFY) begin
                                    w_ctrl.cmd = ovl_pkg::CMD_WRITE;
                                    w_sel      = w_first;
                                    w_wdata    = r_nv;
                                    n_value    = r_nv;
                                end
                            end
                        end
                        ovl_pkg::OP_DUMP: begin
                            if (w_empty) begin
                                w_emit   = 1'b1;
                                n_status = ovl_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DUMP;
                                n_left  = r_count;
                            end
                        end
                        default: begin
                            // unused opcode: dropped without a result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_DUMP: begin
                if (w_slot) begin
                    // head word goes out and wraps to the tail; count turns restore order
                    w_emit     = 1'b1;
                    n_status   = ovl_pkg::ST_DONE;
                    n_value    = w_data[0];
                    n_last     = (r_left == CW'(1));
                    w_ctrl.cmd = ovl_pkg::CMD_ROTATE;
                    w_sel      = w_tail_sel;
                    w_wdata    = w_data[0];
                    n_left     = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_nv  <= i_new_value;
        end
        if (w_emit) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_last   <= n_last;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_status;
    assign o_value  = r_value;
    assign o_last   = r_last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count past depth");

    a_accept_resolves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RES))
        else $error("accepted word not resolving");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_left != '0 && r_left <= r_count))
        else $error("dump counter out of range");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && n_status == ovl_pkg::ST_FULL) |-> w_full)
        else $error("full reported with room left");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_emit)
        else $error("word emitted while idle");
`endif

endmodule

`default_nettype wire
